// File: src/lmtc_pkg.sv
package lmtc_pkg;

  // fixed field and register widths
  localparam int SAMPLE_W   = 8;
  localparam int SLOT_W     = 2;
  localparam int SCALE_W    = 10;
  localparam int GAIN_W     = 11;
  localparam int ACC_W      = 20;
  localparam int WPROD_W    = SAMPLE_W + SCALE_W;
  localparam int PROD_W     = 31;
  localparam int MUL_A_W    = PROD_W - 8;
  localparam int MUL_W      = MUL_A_W + GAIN_W;
  localparam int QUO_W      = 8;
  localparam int REM_W      = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int CHANNELS   = 3;
  localparam int DIV_STEPS  = QUO_W;

  localparam logic [ACC_W-1:0]   FULL_LEVEL = ACC_W'(255 << 8);
  localparam logic [PROD_W-1:0]  LIMIT      = PROD_W'((255 << 16) + (1 << 15));
  localparam logic [7:0]         BYTE_MAX   = 8'd255;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULLBRIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_RED_BLUE = 3'd7;

  typedef enum logic {
    MUL_GAIN   = 1'b0,
    MUL_RENORM = 1'b1
  } mul_mode_t;

  typedef struct packed {
    logic      accum;
    logic      start;
    logic      mul;
    mul_mode_t mode;
    logic [1:0] ch;
    logic      div_init;
    logic      div_step;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic over;
    logic out_free;
  } status_t;

endpackage

// File: src/lmtc_ctrl.sv
module lmtc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             in_last,
  input  lmtc_pkg::status_t status,
  output logic             in_ready,
  output lmtc_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    IDLE,
    GAIN,
    CHECK,
    DIV,
    RENORM,
    EMIT
  } state_t;

  state_t state;
  logic [1:0] ch;
  logic [$clog2(lmtc_pkg::DIV_STEPS)-1:0] cnt;

  localparam logic [1:0] LAST_CH = 2'(lmtc_pkg::CHANNELS - 1);
  localparam logic [$clog2(lmtc_pkg::DIV_STEPS)-1:0] LAST_STEP =
    ($clog2(lmtc_pkg::DIV_STEPS))'(lmtc_pkg::DIV_STEPS - 1);

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.ch       = ch;
    cmd.accum    = in_fire;
    cmd.start    = in_fire && in_last;
    cmd.mode     = (state == RENORM) ? lmtc_pkg::MUL_RENORM : lmtc_pkg::MUL_GAIN;
    cmd.mul      = (state == GAIN) || (state == RENORM);
    cmd.div_init = (state == CHECK) && status.over;
    cmd.div_step = (state == DIV);
    cmd.load_out = (state == EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      ch    <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_fire && in_last) begin
            state <= GAIN;
            ch    <= '0;
          end
        end
        GAIN: begin
          if (ch == LAST_CH) begin
            state <= CHECK;
          end
          ch <= ch + 2'd1;
        end
        CHECK: begin
          if (status.over) begin
            state <= DIV;
            cnt   <= '0;
          end else begin
            state <= EMIT;
          end
        end
        DIV: begin
          if (cnt == LAST_STEP) begin
            state <= RENORM;
            ch    <= '0;
          end
          cnt <= cnt + 1'b1;
        end
        RENORM: begin
          if (ch == LAST_CH) begin
            state <= EMIT;
          end
          ch <= ch + 2'd1;
        end
        EMIT: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/lmtc_datapath.sv
module lmtc_datapath #(
  parameter int STYLE_SLOTS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [lmtc_pkg::IN_DATA_W-1:0]     in_data,
  input  logic [lmtc_pkg::IN_USER_W-1:0]     in_user,
  input  logic                               cfg_we,
  input  logic [lmtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lmtc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  lmtc_pkg::cmd_t                     cmd,
  output lmtc_pkg::status_t                  status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lmtc_pkg::OUT_DATA_W-1:0]    out_data
);

  localparam int AW = lmtc_pkg::ACC_W;
  localparam int PW = lmtc_pkg::PROD_W;

  // configuration
  logic [lmtc_pkg::SCALE_W-1:0] style_scale [STYLE_SLOTS];
  logic [lmtc_pkg::GAIN_W-1:0]  output_scale;
  logic                         fullbright;
  logic                         invert_output;
  logic                         swap_red_blue;

  logic [AW-1:0]    acc [lmtc_pkg::CHANNELS];
  logic [PW-1:0]    prod [lmtc_pkg::CHANNELS];
  logic [PW-1:0]    max_prod;
  logic [lmtc_pkg::REM_W-1:0] rem;
  logic [lmtc_pkg::QUO_W-1:0] quo;

  logic [lmtc_pkg::SLOT_W-1:0]  slot;
  logic                         has_sample;
  logic                         slot_ok;
  logic [lmtc_pkg::SCALE_W-1:0] weight;
  logic                         add_en;
  logic [lmtc_pkg::SAMPLE_W-1:0] sample [lmtc_pkg::CHANNELS];
  logic [AW-1:0]                acc_next [lmtc_pkg::CHANNELS];

  logic [lmtc_pkg::MUL_A_W-1:0] mul_a;
  logic [lmtc_pkg::GAIN_W-1:0]  mul_b;
  logic [lmtc_pkg::MUL_W-1:0]   mul_full;
  logic [PW-1:0]                mul_out;
  logic [AW-1:0]                acc_sel;
  logic [PW-1:0]                prod_sel;
  logic [lmtc_pkg::REM_W-1:0]   rem_shift;
  logic                         rem_ge;
  logic [7:0]                   chan_byte [lmtc_pkg::CHANNELS];

  assign slot       = in_user[lmtc_pkg::SLOT_W-1:0];
  assign has_sample = in_user[lmtc_pkg::SLOT_W];
  assign slot_ok    = {1'b0, slot} < 3'(STYLE_SLOTS);
  assign add_en     = has_sample && !fullbright && slot_ok;

  always_comb begin
    weight = '0;
    for (int i = 0; i < STYLE_SLOTS; i++) begin
      if (slot == lmtc_pkg::SLOT_W'(i)) begin
        weight = style_scale[i];
      end
    end
  end

  // weighted add with saturation, one lane per channel
  always_comb begin
    logic [lmtc_pkg::WPROD_W-1:0] wprod;
    logic [AW:0]                  sum;
    for (int c = 0; c < lmtc_pkg::CHANNELS; c++) begin
      sample[c] = in_data[c*lmtc_pkg::SAMPLE_W +: lmtc_pkg::SAMPLE_W];
      wprod     = sample[c] * weight;
      sum       = {1'b0, acc[c]} + (AW+1)'(wprod);
      acc_next[c] = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
    end
  end

  always_comb begin
    case (cmd.ch)
      2'd0:    begin acc_sel = acc[0]; prod_sel = prod[0]; end
      2'd1:    begin acc_sel = acc[1]; prod_sel = prod[1]; end
      2'd2:    begin acc_sel = acc[2]; prod_sel = prod[2]; end
      default: begin acc_sel = acc[0]; prod_sel = prod[0]; end
    endcase
  end

  // shared multiplier: gain pass, then renormalize pass
  always_comb begin
    if (cmd.mode == lmtc_pkg::MUL_RENORM) begin
      mul_a = prod_sel[PW-1:8];
      mul_b = lmtc_pkg::GAIN_W'(quo);
    end else begin
      mul_a = lmtc_pkg::MUL_A_W'(fullbright ? lmtc_pkg::FULL_LEVEL : acc_sel);
      mul_b = output_scale;
    end
    mul_full = mul_a * mul_b;
    mul_out  = mul_full[PW-1:0];
  end

  // restoring divide: limit << 8 over the largest product, one bit per step
  assign rem_shift = {rem[lmtc_pkg::REM_W-2:0], 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, max_prod};

  assign status.over     = max_prod > lmtc_pkg::LIMIT;
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    for (int c = 0; c < lmtc_pkg::CHANNELS; c++) begin
      chan_byte[c] = invert_output ? (lmtc_pkg::BYTE_MAX - prod[c][23:16]) : prod[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STYLE_SLOTS; i++) begin
        style_scale[i] <= lmtc_pkg::SCALE_W'(256);
      end
      output_scale  <= lmtc_pkg::GAIN_W'(512);
      fullbright    <= 1'b0;
      invert_output <= 1'b1;
      swap_red_blue <= 1'b0;
    end else if (cfg_we) begin
      for (int i = 0; i < STYLE_SLOTS; i++) begin
        if (cfg_index == lmtc_pkg::CFG_IDX_W'(i)) begin
          style_scale[i] <= cfg_data[lmtc_pkg::SCALE_W-1:0];
        end
      end
      case (cfg_index)
        lmtc_pkg::REG_OUTPUT_SCALE:  output_scale  <= cfg_data;
        lmtc_pkg::REG_FULLBRIGHT:    fullbright    <= cfg_data[0];
        lmtc_pkg::REG_INVERT_OUTPUT: invert_output <= cfg_data[0];
        lmtc_pkg::REG_SWAP_RED_BLUE: swap_red_blue <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < lmtc_pkg::CHANNELS; c++) begin
        acc[c] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        for (int c = 0; c < lmtc_pkg::CHANNELS; c++) begin
          acc[c] <= '0;
        end
      end else if (cmd.accum && add_en) begin
        for (int c = 0; c < lmtc_pkg::CHANNELS; c++) begin
          acc[c] <= acc_next[c];
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      max_prod <= '0;
    end else if (cmd.mul && cmd.mode == lmtc_pkg::MUL_GAIN && mul_out > max_prod) begin
      max_prod <= mul_out;
    end
    if (cmd.mul) begin
      case (cmd.ch)
        2'd0:    prod[0] <= mul_out;
        2'd1:    prod[1] <= mul_out;
        2'd2:    prod[2] <= mul_out;
        default: ;
      endcase
    end
    if (cmd.div_init) begin
      rem <= lmtc_pkg::REM_W'(lmtc_pkg::LIMIT);
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? (rem_shift - {1'b0, max_prod}) : rem_shift;
      quo <= {quo[lmtc_pkg::QUO_W-2:0], rem_ge};
    end
    if (cmd.load_out) begin
      out_data <= {lmtc_pkg::BYTE_MAX,
                   swap_red_blue ? chan_byte[0] : chan_byte[2],
                   chan_byte[1],
                   swap_red_blue ? chan_byte[2] : chan_byte[0]};
    end
  end

endmodule

// File: src/lightmap_texel_combine.sv
// Lightmap texel combine: each input word carries one light style's RGB sample, which is
// weighted by that style's 2.8 scale and added into saturating 20-bit accumulators; the
// word with tlast closes the texel and yields one RGBA output word (alpha 255), after the
// output gain, a hue-keeping renormalize when the brightest channel passes the limit, and
// optional inversion and red/blue swap. For the closing word the three channels go one
// after another through a single shared multiplier for the gain; when a renormalize is
// needed, an 8-step restoring divider then forms the shared reciprocal and the multiplier
// makes a second pass. Input is held off only while a texel is being finished or its word
// cannot yet enter the output register; a new texel may stream in while the previous word
// waits there. Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while the block is idle, and the block itself does not enforce it.
module lightmap_texel_combine #(
  parameter int STYLE_SLOTS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sample_red, sample_green, sample_blue
  input  logic [lmtc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // style_slot, has_sample
  input  logic [lmtc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // byte_zero, byte_one, byte_two, alpha_byte
  output logic [lmtc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [lmtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmtc_pkg::CFG_DATA_W-1:0] cfg_data
);

  lmtc_pkg::cmd_t    cmd;
  lmtc_pkg::status_t status;
  logic              in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  lmtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_last  (s_axis_tlast),
    .status   (status),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  lmtc_datapath #(
    .STYLE_SLOTS (STYLE_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
